[rtl/sdc_pkg.sv]
// shared constants, tables and round functions for the sha-256 digest checker
package sdc_pkg;

    localparam int ROUNDS    = 64;
    localparam int CFG_IDX_W = 3;
    localparam int LEN_W     = 61;

    localparam logic [CFG_IDX_W-1:0] CFG_EXP_LEN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXP_DIG0 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EXP_DIG1 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_EXP_DIG2 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_EXP_DIG3 = 3'd4;

    localparam logic [7:0] PAD_BYTE  = 8'h80;
    localparam logic [5:0] LEN_START = 6'd56;

    localparam logic [31:0] ROUND_K [ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] INIT_H [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage

[rtl/sha256_digest_check_top.sv]
// sha-256 over a byte stream with a check against a configured length and digest
//
// input channel: one request per item (i_data_byte, i_has_byte, i_last_byte) on
// i_in_valid / o_in_ready. a byte with i_has_byte low is dropped; i_last_byte ends
// the message. while o_in_ready is high, bytes shift one per cycle into a 16-word
// schedule window; the 64th byte of a block starts a compression on the single
// shared round unit, one round per cycle, then a fold into the hash (S_HADD),
// during all of which o_in_ready is low. after the last item the block shifts in
// the padding one byte per cycle outside compressions (up to 72 bytes, one or two
// compressions), then shows the eight digest words on o_out_valid / i_out_ready,
// word 0 first. o_digest_match is set on the last word when length and digest
// agree with the registers. a stalled receiver simply holds the current word; no
// new item is taken until word 7 is taken.
// configuration: i_cfg_valid / o_cfg_ready (always ready), i_cfg_index 0 is the
// expected length, 1 to 4 the expected digest; other indexes are ignored.
// reset (synchronous, active low) clears the control and config registers, restores
// the initial hash and a zero byte count, and leaves the block idle and ready.
module sha256_digest_check_top
    import sdc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [63:0]          i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [7:0]           i_data_byte,
    input  logic                 i_has_byte,
    input  logic                 i_last_byte,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [31:0]          o_digest_word,
    output logic [2:0]           o_word_index,
    output logic                 o_last_word,
    output logic                 o_digest_match
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_ROUND  = 7'b0000010,
        S_HADD   = 7'b0000100,
        S_PAD80  = 7'b0001000,
        S_PADZ   = 7'b0010000,
        S_PADLEN = 7'b0100000,
        S_OUT    = 7'b1000000
    } t_state;

    localparam logic [5:0] LAST_ROUND = 6'(ROUNDS - 1);

    t_state r_state, n_state;
    t_state r_after, n_after;

    logic [LEN_W-1:0] r_exp_len;
    logic [63:0]      r_exp_dig [4];

    logic [31:0]      r_hash [8];
    logic [31:0]      n_hash [8];
    logic [31:0]      r_v    [8];
    logic [31:0]      n_v    [8];
    logic [31:0]      r_w    [16];
    logic [31:0]      n_w    [16];
    logic [LEN_W-1:0] r_total, n_total;
    logic [5:0]       r_fill, n_fill;
    logic [5:0]       r_round, n_round;
    logic [2:0]       r_idx, n_idx;
    logic             r_match, n_match;

    logic             in_acc, out_acc;
    logic             shift_en, start_cmp;
    logic [7:0]       shift_byte;
    t_state           next_phase;
    logic [63:0]      len_bits, len_shifted;
    logic [31:0]      t1, s0, maj, ch, new_w, want;
    logic             word_eq;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign in_acc      = i_in_valid & o_in_ready;
    assign out_acc     = o_out_valid & i_out_ready;

    assign want    = r_idx[0] ? r_exp_dig[r_idx[2:1]][31:0] : r_exp_dig[r_idx[2:1]][63:32];
    assign word_eq = (r_hash[r_idx] == want);

    assign o_digest_word  = r_hash[r_idx];
    assign o_word_index   = r_idx;
    assign o_last_word    = (r_idx == 3'd7);
    assign o_digest_match = o_last_word & r_match & word_eq & (r_total == r_exp_len);

    // big-endian bit count, one byte per padding cycle
    assign len_bits    = {r_total, 3'b000};
    assign len_shifted = len_bits >> {~r_fill[2:0], 3'b000};

    // shared round datapath
    assign ch    = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
    assign maj   = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
    assign s0    = big_sigma0(r_v[0]);
    assign t1    = r_v[7] + big_sigma1(r_v[4]) + ch + ROUND_K[r_round] + r_w[0];
    assign new_w = small_sigma1(r_w[14]) + r_w[9] + small_sigma0(r_w[1]) + r_w[0];

    always_comb begin
        n_state    = r_state;
        n_after    = r_after;
        n_hash     = r_hash;
        n_v        = r_v;
        n_w        = r_w;
        n_total    = r_total;
        n_fill     = r_fill;
        n_round    = r_round;
        n_idx      = r_idx;
        n_match    = r_match;
        shift_en   = 1'b0;
        shift_byte = 8'h00;
        next_phase = r_state;

        unique case (r_state)
            S_IDLE: begin
                shift_byte = i_data_byte;
                shift_en   = in_acc & i_has_byte;
                next_phase = (in_acc & i_last_byte) ? S_PAD80 : S_IDLE;
                if (shift_en) begin
                    n_total = r_total + LEN_W'(1);
                end
            end
            S_PAD80: begin
                shift_en   = 1'b1;
                shift_byte = PAD_BYTE;
                next_phase = S_PADZ;
            end
            S_PADZ: begin
                if (r_fill == LEN_START) begin
                    next_phase = S_PADLEN;
                end else begin
                    shift_en   = 1'b1;
                    next_phase = S_PADZ;
                end
            end
            S_PADLEN: begin
                shift_en   = 1'b1;
                shift_byte = len_shifted[7:0];
                next_phase = (r_fill == 6'd63) ? S_OUT : S_PADLEN;
            end
            S_ROUND: begin
                next_phase = (r_round == LAST_ROUND) ? S_HADD : S_ROUND;
                for (int j = 0; j < 15; j++) begin
                    n_w[j] = r_w[j+1];
                end
                n_w[15] = new_w;
                n_v[7]  = r_v[6];
                n_v[6]  = r_v[5];
                n_v[5]  = r_v[4];
                n_v[4]  = r_v[3] + t1;
                n_v[3]  = r_v[2];
                n_v[2]  = r_v[1];
                n_v[1]  = r_v[0];
                n_v[0]  = t1 + s0 + maj;
                n_round = r_round + 6'd1;
            end
            S_HADD: begin
                next_phase = r_after;
                for (int j = 0; j < 8; j++) begin
                    n_hash[j] = r_hash[j] + r_v[j];
                end
            end
            S_OUT: begin
                next_phase = S_OUT;
                if (out_acc) begin
                    if (o_last_word) begin
                        n_hash     = INIT_H;
                        n_total    = '0;
                        n_idx      = 3'd0;
                        n_match    = 1'b1;
                        next_phase = S_IDLE;
                    end else begin
                        n_idx   = r_idx + 3'd1;
                        n_match = r_match & word_eq;
                    end
                end
            end
            default: begin
                next_phase = S_IDLE;
            end
        endcase

        // byte shift into the schedule window; a full block starts a compression
        start_cmp = shift_en & (r_fill == 6'd63);
        if (shift_en) begin
            for (int j = 0; j < 15; j++) begin
                n_w[j] = {r_w[j][23:0], r_w[j+1][31:24]};
            end
            n_w[15] = {r_w[15][23:0], shift_byte};
            n_fill  = r_fill + 6'd1;
        end

        if (start_cmp) begin
            n_v     = r_hash;
            n_round = 6'd0;
            n_after = next_phase;
            n_state = S_ROUND;
        end else begin
            n_state = next_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_after   <= S_IDLE;
            r_hash    <= INIT_H;
            r_total   <= '0;
            r_fill    <= '0;
            r_round   <= '0;
            r_idx     <= '0;
            r_match   <= 1'b1;
            r_exp_len <= '0;
            r_exp_dig <= '{default: '0};
        end else begin
            r_state <= n_state;
            r_after <= n_after;
            r_hash  <= n_hash;
            r_total <= n_total;
            r_fill  <= n_fill;
            r_round <= n_round;
            r_idx   <= n_idx;
            r_match <= n_match;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_EXP_LEN:  r_exp_len    <= i_cfg_data[LEN_W-1:0];
                    CFG_EXP_DIG0: r_exp_dig[0] <= i_cfg_data;
                    CFG_EXP_DIG1: r_exp_dig[1] <= i_cfg_data;
                    CFG_EXP_DIG2: r_exp_dig[2] <= i_cfg_data;
                    CFG_EXP_DIG3: r_exp_dig[3] <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    // working variables and schedule window carry no reset
    always_ff @(posedge i_clk) begin
        r_v <= n_v;
        r_w <= n_w;
    end

endmodule

[rtl/sdc_checker.sv]
// port-level checks for the sha-256 digest checker, bound to the top level
module sdc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [31:0] o_digest_word,
    input logic [2:0]  o_word_index,
    input logic        o_last_word,
    input logic        o_digest_match
);

    // no new request is taken while digest words are pending
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input ready while digest output pending");

    // digest words follow back to back in order
    a_word_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && !o_last_word) |=>
        (o_out_valid && o_word_index == $past(o_word_index) + 3'd1))
        else $error("digest word sequence broken");

    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_last_word == (o_word_index == 3'd7)))
        else $error("last word flag out of place");

    a_match_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_digest_match) |-> o_last_word)
        else $error("match flag before last word");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
        (o_out_valid && $stable(o_digest_word) && $stable(o_word_index)))
        else $error("stalled digest word changed");

endmodule

bind sha256_digest_check_top sdc_checker u_sdc_checker (.*);
